// File: rtl/rs_systematic_encoder_unit_assert.svh
// Assertion macros used by the encoder top level.
`ifndef RS_SYSTEMATIC_ENCODER_UNIT_ASSERT_SVH
`define RS_SYSTEMATIC_ENCODER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RSE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RSE_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RSE_ASSERT(name, prop, msg)
`define RSE_ASSERT_RST(name, prop, msg)
`endif
`endif

// File: rtl/rse_pkg.sv
// Package: GF(256) helpers, constants and cell control type for the RS encoder.
package rse_pkg;

  localparam int SYM_W        = 8;
  localparam int CFG_W        = 6;
  localparam int GF_ORDER     = 255;
  localparam int MAX_PARITY_D = 32;
  localparam int RESET_PARITY = 16;
  localparam logic [SYM_W-1:0] GF_REDUCE = 8'h1D;

  typedef struct packed {
    logic init;       // load x^0 generator, clear remainder
    logic build;      // one generator product step
    logic enc;        // message beat accepted
    logic last;       // input beat carries tlast; used only together with enc
    logic shift_par;  // parity beat taken downstream
  } cell_ctl_t;

  function automatic logic [SYM_W-1:0] gf_xtime(input logic [SYM_W-1:0] a);
    gf_xtime = {a[SYM_W-2:0], 1'b0} ^ (a[SYM_W-1] ? GF_REDUCE : '0);
  endfunction

  function automatic logic [SYM_W-1:0] gf_mul(input logic [SYM_W-1:0] a,
                                              input logic [SYM_W-1:0] b);
    logic [SYM_W-1:0] x;
    logic [SYM_W-1:0] acc;
    x   = a;
    acc = '0;
    for (int i = 0; i < SYM_W; i++) begin
      if (b[i]) acc = acc ^ x;
      x = gf_xtime(x);
    end
    gf_mul = acc;
  endfunction

endpackage

// File: rtl/rs_systematic_encoder_unit.sv
// Top level: systematic Reed-Solomon encoder over GF(256), chain of LFSR cells.
//
// Takes one message byte per clock, highest degree first, through a row of
// MAX_PARITY cells that each hold one remainder byte and one generator
// coefficient. On the beat marked tlast the remainder moves into a parity
// drain row in the same cells and L = parity_count parity bytes leave, one per
// cycle while m_tready is high, degree L-1 first; the next codeword's message
// streams in meanwhile. A tlast beat is held off until the previous codeword's
// parity has drained (it is taken in the cycle the final parity beat goes).
// After reset and after every parity_count write the generator is rebuilt in
// place, one root per cycle, and input is held off until the rebuild ends.
// m_tuser flags a codeword whose message count plus L exceeded 255 symbols.
`include "rs_systematic_encoder_unit_assert.svh"
module rs_systematic_encoder_unit #(
  parameter int MAX_PARITY = rse_pkg::MAX_PARITY_D
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [rse_pkg::SYM_W-1:0] s_tdata,   // [7:0] message_symbol
  input  logic                      s_tlast,   // last_symbol
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [rse_pkg::SYM_W-1:0] m_tdata,   // [7:0] parity_symbol
  output logic                      m_tlast,   // last_parity
  output logic                      m_tuser,   // [0] overlength
  input  logic                      cfg_we,
  input  logic [rse_pkg::CFG_W-1:0] cfg_wdata  // parity_count
);
  import rse_pkg::*;

  localparam int LW   = $clog2(MAX_PARITY + 1);
  localparam int IW   = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1;
  localparam int SW   = $clog2(GF_ORDER + MAX_PARITY + 1);
  localparam int CMPW = (LW > CFG_W) ? LW : CFG_W;
  localparam logic [LW-1:0] RST_L =
    LW'((RESET_PARITY > MAX_PARITY) ? MAX_PARITY : RESET_PARITY);

  logic [LW-1:0]    parity;
  logic             init_pend;
  logic             building;
  logic [LW-1:0]    step_cnt;
  logic [SYM_W-1:0] root;
  logic [SYM_W-1:0] sym_cnt;
  logic             ovf;
  logic [LW-1:0]    out_cnt;
  logic             out_ovf;

  logic [SYM_W-1:0] rem_q [MAX_PARITY];
  logic [SYM_W-1:0] g_q   [MAX_PARITY];
  logic [SYM_W-1:0] par_q [MAX_PARITY];

  logic             s_acc;
  logic             m_acc;
  logic [IW-1:0]    top_idx;
  logic [SYM_W-1:0] fb;
  logic [SYM_W-1:0] cnt_inc;
  logic             ovf_hit;
  logic [CMPW-1:0]  cfg_ext;
  logic [LW-1:0]    parity_next;
  cell_ctl_t        ctl;

  assign top_idx  = IW'(parity - LW'(1));
  assign m_tvalid = (out_cnt != '0);
  assign m_tlast  = (out_cnt == LW'(1));
  assign m_tuser  = out_ovf;
  assign m_tdata  = par_q[top_idx];
  assign s_tready = !init_pend && !building &&
                    (!s_tlast || out_cnt == '0 || (m_tlast && m_tready));
  assign s_acc    = s_tvalid && s_tready;
  assign m_acc    = m_tvalid && m_tready;
  assign fb       = s_tdata ^ rem_q[top_idx];

  always_comb begin
    cnt_inc = (sym_cnt == SYM_W'(GF_ORDER)) ? sym_cnt : sym_cnt + SYM_W'(1);
    ovf_hit = (SW'(cnt_inc) + SW'(parity)) > SW'(GF_ORDER);
    cfg_ext = CMPW'(cfg_wdata);
    if (cfg_ext == '0) begin
      parity_next = LW'(1);
    end else if (cfg_ext > CMPW'(MAX_PARITY)) begin
      parity_next = LW'(MAX_PARITY);
    end else begin
      parity_next = LW'(cfg_ext);
    end
    ctl.init      = init_pend;
    ctl.build     = building;
    ctl.enc       = s_acc;
    ctl.last      = s_tlast;
    ctl.shift_par = m_acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parity    <= RST_L;
      init_pend <= 1'b1;
      building  <= 1'b0;
      step_cnt  <= '0;
      root      <= SYM_W'(1);
      sym_cnt   <= '0;
      ovf       <= 1'b0;
      out_cnt   <= '0;
      out_ovf   <= 1'b0;
    end else begin
      if (init_pend) begin
        init_pend <= 1'b0;
        building  <= 1'b1;
        step_cnt  <= '0;
        root      <= SYM_W'(1);
      end else if (building) begin
        root     <= gf_xtime(root);
        step_cnt <= step_cnt + LW'(1);
        if (step_cnt == parity - LW'(1)) building <= 1'b0;
      end

      if (s_acc) begin
        if (s_tlast) begin
          sym_cnt <= '0;
          ovf     <= 1'b0;
          out_ovf <= ovf || ovf_hit;
          out_cnt <= parity;
        end else begin
          sym_cnt <= cnt_inc;
          ovf     <= ovf || ovf_hit;
          if (m_acc) out_cnt <= out_cnt - LW'(1);
        end
      end else if (m_acc) begin
        out_cnt <= out_cnt - LW'(1);
      end

      if (cfg_we) begin
        parity    <= parity_next;
        init_pend <= 1'b1;
        sym_cnt   <= '0;
        ovf       <= 1'b0;
      end
    end
  end

  for (genvar j = 0; j < MAX_PARITY; j++) begin : g_cells
    logic [SYM_W-1:0] rem_lo;
    logic [SYM_W-1:0] g_lo;
    logic [SYM_W-1:0] par_lo;
    if (j == 0) begin : g_first
      assign rem_lo = '0;
      assign g_lo   = '0;
      assign par_lo = '0;
    end else begin : g_rest
      assign rem_lo = rem_q[j-1];
      assign g_lo   = g_q[j-1];
      assign par_lo = par_q[j-1];
    end
    rse_cell u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .g_init (j == 0),
      .fb     (fb),
      .root   (root),
      .rem_lo (rem_lo),
      .g_lo   (g_lo),
      .par_lo (par_lo),
      .rem    (rem_q[j]),
      .g      (g_q[j]),
      .par    (par_q[j])
    );
  end

  `RSE_ASSERT_RST(a_rst_rebuild, rst |=> init_pend, "reset did not schedule a generator rebuild")
  `RSE_ASSERT(a_cfg_rebuild, cfg_we |=> init_pend, "config write did not schedule a rebuild")
  `RSE_ASSERT(a_build_bound, building |-> (step_cnt < parity), "generator build overran L steps")
  `RSE_ASSERT(a_last_drains, (s_acc && s_tlast) |=> m_tvalid, "last symbol produced no parity")
  `RSE_ASSERT(a_drain_ends, (m_acc && m_tlast && !(s_acc && s_tlast)) |=> !m_tvalid, "parity beat after last_parity")

endmodule

// File: rtl/rse_cell.sv
// One LFSR stage: remainder, generator coefficient and parity drain register.
module rse_cell (
  input  logic                     clk,
  input  rse_pkg::cell_ctl_t       ctl,
  input  logic                     g_init,
  input  logic [rse_pkg::SYM_W-1:0] fb,
  input  logic [rse_pkg::SYM_W-1:0] root,
  input  logic [rse_pkg::SYM_W-1:0] rem_lo,
  input  logic [rse_pkg::SYM_W-1:0] g_lo,
  input  logic [rse_pkg::SYM_W-1:0] par_lo,
  output logic [rse_pkg::SYM_W-1:0] rem,
  output logic [rse_pkg::SYM_W-1:0] g,
  output logic [rse_pkg::SYM_W-1:0] par
);
  import rse_pkg::*;

  logic [SYM_W-1:0] rem_next;
  logic [SYM_W-1:0] g_next;

  always_comb begin
    rem_next = rem_lo ^ gf_mul(g, fb);
    // generator times (x + root)
    g_next   = g_lo ^ gf_mul(root, g);
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      g   <= g_init ? SYM_W'(1) : '0;
      rem <= '0;
    end else begin
      if (ctl.build) g <= g_next;
      if (ctl.enc) rem <= ctl.last ? '0 : rem_next;
    end
    if (ctl.enc && ctl.last) begin
      par <= rem_next;
    end else if (ctl.shift_par) begin
      par <= par_lo;
    end
  end

endmodule
